// File: design/great_circle_distance_unit_defines.svh
`ifndef GREAT_CIRCLE_DISTANCE_UNIT_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_UNIT_DEFINES_SVH

// same-cycle implication on i_clk, off during reset
`define GCD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcd check failed");

// next-cycle implication on i_clk, off during reset
`define GCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcd check failed");

// next-cycle implication on i_clk, checked through reset
`define GCD_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("gcd reset check failed");

`endif

// File: design/gcd_pkg.sv
package gcd_pkg;

    localparam int RADIUS_W = 23;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [27:0] PI180 = 28'sd74961321;
    localparam logic signed [31:0] LAT_LIM = 32'sd377487360;
    localparam logic signed [31:0] LON_LIM = 32'sd754974720;
    localparam logic [32:0] DEG90_Q23 = 33'd754974720;
    localparam logic [32:0] DEG180_Q23 = 33'd1509949440;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [31:0] KM_RECIP = 32'd2199023255;
    localparam logic [33:0] KM_DIV = 34'd125;

    localparam logic [1:0] FUNC_RAD = 2'd0;
    localparam logic [1:0] FUNC_M = 2'd1;
    localparam logic [1:0] FUNC_KM = 2'd2;

    localparam logic [29:0] ATAN_TAB [0:31] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] start_lat;
        logic signed [31:0] start_lon;
        logic signed [31:0] end_lat;
        logic signed [31:0] end_lon;
    } t_in;

    typedef struct packed {
        logic [31:0] distance;
        logic        invalid;
    } t_out;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_rot;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] root;
    } t_sqrt;

    typedef struct packed {
        logic       valid;
        logic       invalid;
        logic [1:0] func;
    } t_side;

endpackage

// File: design/gcd_rot_cell.sv
module gcd_rot_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  gcd_pkg::t_rot   i_d,
    output gcd_pkg::t_rot   o_d
);

    localparam logic signed [33:0] ATAN = $signed({4'b0, gcd_pkg::ATAN_TAB[STEP]});

    gcd_pkg::t_rot r_d;
    gcd_pkg::t_rot n_d;
    logic signed [33:0] dx;
    logic signed [33:0] dy;

    always_comb begin
        dx = $signed(i_d.x) >>> STEP;
        dy = $signed(i_d.y) >>> STEP;
        if (!i_d.z[33]) begin
            n_d.x = i_d.x - dy;
            n_d.y = i_d.y + dx;
            n_d.z = i_d.z - ATAN;
        end else begin
            n_d.x = i_d.x + dy;
            n_d.y = i_d.y - dx;
            n_d.z = i_d.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// File: design/gcd_vec_cell.sv
module gcd_vec_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  gcd_pkg::t_rot   i_d,
    output gcd_pkg::t_rot   o_d
);

    localparam logic signed [33:0] ATAN = $signed({4'b0, gcd_pkg::ATAN_TAB[STEP]});

    gcd_pkg::t_rot r_d;
    gcd_pkg::t_rot n_d;
    logic signed [33:0] dx;
    logic signed [33:0] dy;

    always_comb begin
        dx = $signed(i_d.x) >>> STEP;
        dy = $signed(i_d.y) >>> STEP;
        if (!i_d.y[33]) begin
            n_d.x = i_d.x + dy;
            n_d.y = i_d.y - dx;
            n_d.z = i_d.z + ATAN;
        end else begin
            n_d.x = i_d.x - dy;
            n_d.y = i_d.y + dx;
            n_d.z = i_d.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// File: design/gcd_sqrt_cell.sv
module gcd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  gcd_pkg::t_sqrt  i_d,
    output gcd_pkg::t_sqrt  o_d
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    gcd_pkg::t_sqrt r_d;
    gcd_pkg::t_sqrt n_d;
    logic [63:0] trial;

    always_comb begin
        trial = i_d.root + BIT;
        if (i_d.v >= trial) begin
            n_d.v = i_d.v - trial;
            n_d.root = (i_d.root >> 1) + BIT;
        end else begin
            n_d.v = i_d.v;
            n_d.root = i_d.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// File: design/great_circle_distance_unit.sv
// throughput: one transaction per cycle while the output is not stalled, set
// by the rotation, square root and vectoring cell chains that each advance
// one cell per cycle
// a stalled output holds the whole pipeline
// synchronous active-low reset clears all valid bits; radius returns to 6371000 m
module great_circle_distance_unit #(
    parameter int CORDIC_STEPS = 30
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  gcd_pkg::t_in                  i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output gcd_pkg::t_out                 o_result,
    input  logic                          i_cfg_we,
    input  logic [gcd_pkg::RADIUS_W-1:0]  i_cfg_wdata
);

    localparam int SQ_STEPS = 32;

    logic adv;

    logic [gcd_pkg::RADIUS_W-1:0] r_radius;

    logic          r_v0;
    gcd_pkg::t_in  r_in0;

    gcd_pkg::t_side     r_s1;
    logic signed [31:0] r_lats1;
    logic signed [31:0] r_late1;
    logic [32:0]        r_mlat1;
    logic [32:0]        r_mlon1;

    gcd_pkg::t_side     r_s2;
    logic signed [33:0] r_ang2 [0:3];

    gcd_pkg::t_side r_rside [0:CORDIC_STEPS-1];
    gcd_pkg::t_side r_mside [0:2];
    gcd_pkg::t_side r_qside [0:SQ_STEPS-1];
    gcd_pkg::t_side r_vside [0:CORDIC_STEPS-1];
    gcd_pkg::t_side r_fside [0:3];

    gcd_pkg::t_rot  rot_d [0:3][0:CORDIC_STEPS];
    gcd_pkg::t_sqrt sq_d  [0:1][0:SQ_STEPS];
    gcd_pkg::t_rot  vec_d [0:CORDIC_STEPS];

    logic signed [33:0] r_p1;
    logic signed [33:0] r_c12;
    logic signed [33:0] r_sl2;
    logic signed [33:0] r_p1b;
    logic signed [33:0] r_t;
    gcd_pkg::t_sqrt     r_sqa;
    gcd_pkg::t_sqrt     r_sqb;

    logic [31:0] r_rad;
    logic [31:0] r_rad1;
    logic [54:0] r_prod;
    logic [31:0] r_rad2;
    logic [31:0] r_m2;
    logic [32:0] r_u2;
    logic [31:0] r_rad3;
    logic [31:0] r_m3;
    logic [32:0] r_u3;
    logic [64:0] r_qm;

    logic          r_out_valid;
    gcd_pkg::t_out r_out;

    // stage 1 logic
    logic               bad;
    logic signed [32:0] dlat;
    logic signed [32:0] dlon;
    logic [32:0]        mlat;
    logic [32:0]        mlon;

    // stage 2 logic
    logic signed [59:0] plats;
    logic signed [59:0] plate;
    logic [59:0]        pmlat;
    logic [59:0]        pmlon;

    // product stages
    logic signed [63:0] psd;
    logic signed [63:0] pc;
    logic signed [63:0] psl;
    logic signed [63:0] pt;
    logic signed [34:0] asum;
    logic [30:0]        aclamp;

    // result stages
    logic signed [33:0] zend;
    logic [34:0]        rad2x;
    logic [55:0]        msum;
    logic [55:0]        ksum;
    logic [26:0]        qest;
    logic [33:0]        rem;
    logic [31:0]        qkm;
    logic [31:0]        dist_sel;

    assign adv = !(r_out_valid && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= gcd_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in0 <= i_item;
        end
    end

    // range check and absolute differences
    always_comb begin
        bad = (r_in0.start_lat >= gcd_pkg::LAT_LIM) || (r_in0.start_lat <= -gcd_pkg::LAT_LIM)
            || (r_in0.end_lat >= gcd_pkg::LAT_LIM) || (r_in0.end_lat <= -gcd_pkg::LAT_LIM)
            || (r_in0.start_lon >= gcd_pkg::LON_LIM) || (r_in0.start_lon <= -gcd_pkg::LON_LIM)
            || (r_in0.end_lon >= gcd_pkg::LON_LIM) || (r_in0.end_lon <= -gcd_pkg::LON_LIM);
        dlat = $signed({r_in0.end_lat[31], r_in0.end_lat})
             - $signed({r_in0.start_lat[31], r_in0.start_lat});
        dlon = $signed({r_in0.end_lon[31], r_in0.end_lon})
             - $signed({r_in0.start_lon[31], r_in0.start_lon});
        mlat = dlat[32] ? 33'(-dlat) : 33'(dlat);
        mlon = dlon[32] ? 33'(-dlon) : 33'(dlon);
        if (mlon > gcd_pkg::DEG90_Q23) begin
            mlon = gcd_pkg::DEG180_Q23 - mlon;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (adv) begin
            r_s1 <= '{valid: r_v0, invalid: bad, func: r_in0.func};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lats1 <= r_in0.start_lat;
            r_late1 <= r_in0.end_lat;
            r_mlat1 <= mlat;
            r_mlon1 <= mlon;
        end
    end

    // degrees to radians
    always_comb begin
        plats = 60'(r_lats1) * 60'(gcd_pkg::PI180) + 60'sd8388608;
        plate = 60'(r_late1) * 60'(gcd_pkg::PI180) + 60'sd8388608;
        pmlat = 60'(r_mlat1) * 60'(gcd_pkg::PI180) + 60'd16777216;
        pmlon = 60'(r_mlon1) * 60'(gcd_pkg::PI180) + 60'd16777216;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else if (adv) begin
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ang2[0] <= plats[57:24];
            r_ang2[1] <= plate[57:24];
            r_ang2[2] <= $signed(pmlat[58:25]);
            r_ang2[3] <= $signed(pmlon[58:25]);
        end
    end

    // rotation chains: lanes start lat, end lat, half dlat, half dlon
    for (genvar l = 0; l < 4; l++) begin : g_rot_lane
        assign rot_d[l][0] = '{x: gcd_pkg::CORDIC_K, y: '0, z: r_ang2[l]};
        for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_rot_cell
            gcd_rot_cell #(.STEP(s)) u_cell (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_d   (rot_d[l][s]),
                .o_d   (rot_d[l][s+1])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_rside[k] <= '0;
                r_vside[k] <= '0;
            end
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_qside[k] <= '0;
            end
            for (int k = 0; k < 3; k++) begin
                r_mside[k] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                r_fside[k] <= '0;
            end
        end else if (adv) begin
            r_rside[0] <= r_s2;
            for (int k = 1; k < CORDIC_STEPS; k++) begin
                r_rside[k] <= r_rside[k-1];
            end
            r_mside[0] <= r_rside[CORDIC_STEPS-1];
            r_mside[1] <= r_mside[0];
            r_mside[2] <= r_mside[1];
            r_qside[0] <= r_mside[2];
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_qside[k] <= r_qside[k-1];
            end
            r_vside[0] <= r_qside[SQ_STEPS-1];
            for (int k = 1; k < CORDIC_STEPS; k++) begin
                r_vside[k] <= r_vside[k-1];
            end
            r_fside[0] <= r_vside[CORDIC_STEPS-1];
            r_fside[1] <= r_fside[0];
            r_fside[2] <= r_fside[1];
            r_fside[3] <= r_fside[2];
        end
    end

    // haversine term a
    always_comb begin
        psd = 64'($signed(rot_d[2][CORDIC_STEPS].y[31:0]))
            * 64'($signed(rot_d[2][CORDIC_STEPS].y[31:0])) + 64'sd536870912;
        pc  = 64'($signed(rot_d[0][CORDIC_STEPS].x[31:0]))
            * 64'($signed(rot_d[1][CORDIC_STEPS].x[31:0])) + 64'sd536870912;
        psl = 64'($signed(rot_d[3][CORDIC_STEPS].y[31:0]))
            * 64'($signed(rot_d[3][CORDIC_STEPS].y[31:0])) + 64'sd536870912;
        pt  = 64'($signed(r_c12[31:0])) * 64'($signed(r_sl2[31:0])) + 64'sd536870912;
        asum = 35'(r_p1b) + 35'(r_t);
        if (asum[34]) begin
            aclamp = '0;
        end else if (asum > 35'(gcd_pkg::ONE_Q30)) begin
            aclamp = gcd_pkg::ONE_Q30;
        end else begin
            aclamp = asum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1  <= psd[63:30];
            r_c12 <= pc[63:30];
            r_sl2 <= psl[63:30];
            r_p1b <= r_p1;
            r_t   <= pt[63:30];
            r_sqa <= '{v: {3'b0, aclamp, 30'b0}, root: '0};
            r_sqb <= '{v: {3'b0, 31'(gcd_pkg::ONE_Q30 - aclamp), 30'b0}, root: '0};
        end
    end

    // square root chains
    assign sq_d[0][0] = r_sqa;
    assign sq_d[1][0] = r_sqb;
    for (genvar l = 0; l < 2; l++) begin : g_sq_lane
        for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sq_cell
            gcd_sqrt_cell #(.STEP(s)) u_cell (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_d   (sq_d[l][s]),
                .o_d   (sq_d[l][s+1])
            );
        end
    end

    // vectoring chain for atan2(sqrt(a), sqrt(1 - a))
    assign vec_d[0] = '{
        x: $signed({1'b0, sq_d[1][SQ_STEPS].root[32:0]}),
        y: $signed({1'b0, sq_d[0][SQ_STEPS].root[32:0]}),
        z: '0
    };
    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_vec_cell
        gcd_vec_cell #(.STEP(s)) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (vec_d[s]),
            .o_d   (vec_d[s+1])
        );
    end

    // unit conversion and result select
    always_comb begin
        zend = vec_d[CORDIC_STEPS].z;
        rad2x = zend[33] ? '0 : {zend[33:0], 1'b0};
        msum = 56'(r_prod) + 56'd536870912;
        ksum = 56'(r_prod) + 56'd524288000;
        qest = r_qm[64:38];
        rem = 34'(r_u3) - 34'(qest) * gcd_pkg::KM_DIV;
        qkm = (rem >= gcd_pkg::KM_DIV) ? 32'(qest) + 32'd1 : 32'(qest);
        case (r_fside[3].func)
            gcd_pkg::FUNC_M:   dist_sel = r_m3;
            gcd_pkg::FUNC_KM:  dist_sel = qkm;
            gcd_pkg::FUNC_RAD: dist_sel = r_rad3;
            default:           dist_sel = r_rad3;
        endcase
        if (r_fside[3].invalid) begin
            dist_sel = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rad  <= (rad2x > 35'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : rad2x[31:0];
            r_rad1 <= r_rad;
            r_prod <= 55'(r_rad) * 55'(r_radius);
            r_rad2 <= r_rad1;
            r_m2   <= 32'(msum[55:30]);
            r_u2   <= ksum[55:23];
            r_rad3 <= r_rad2;
            r_m3   <= r_m2;
            r_u3   <= r_u2;
            r_qm   <= 65'(r_u2) * 65'(gcd_pkg::KM_RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_fside[3].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= '{distance: dist_sel, invalid: r_fside[3].invalid};
        end
    end

endmodule

// File: design/gcd_checker.sv
`include "great_circle_distance_unit_defines.svh"

module gcd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_stall,
    input logic          o_valid,
    input logic          o_stall,
    input gcd_pkg::t_out o_result
);

    `GCD_ASSERT_NOW(a_invalid_zero, o_valid && o_result.invalid, o_result.distance == 32'd0)
    `GCD_ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall)
    `GCD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_result))
    `GCD_ASSERT_RST(a_reset_clear, !i_rst_n, !o_valid && !o_stall)

endmodule

bind great_circle_distance_unit gcd_checker u_gcd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_stall  (i_stall),
    .o_valid  (o_valid),
    .o_stall  (o_stall),
    .o_result (o_result)
);
